@@ design/lvm_pkg.sv @@
// Shared widths, latencies, types and rounding helpers for the look-at view matrix.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lvm_pkg;

    localparam int FRAC_BITS = 16;

    localparam int IN_W   = 32;
    localparam int D_W    = IN_W + 1;
    localparam int NE_W   = IN_W + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int AX_W   = FRAC_BITS + 2;
    localparam int UP_W   = AX_W + 1;
    localparam int CP_W   = IN_W + AX_W;
    localparam int NORM_W = CP_W + 1;
    localparam int MAG_W  = NORM_W;
    localparam int BL_W   = $clog2(MAG_W + 1);
    localparam int W_W    = 30;
    localparam int SQ_W   = 64;
    localparam int LEN_W  = 32;
    localparam int NUM_W  = LEN_W + FRAC_BITS;
    localparam int UP_PW  = 2 * AX_W;
    localparam int DP_W   = UP_W + NE_W;
    localparam int DOT_W  = DP_W + 2;
    localparam int RND_W  = DOT_W - FRAC_BITS;

    localparam int ISQ_STEPS = SQ_W / 2;
    localparam int DIV_STEPS = Q_W;
    localparam int NORM_LAT  = 6 + ISQ_STEPS + 1 + DIV_STEPS + 1;
    localparam int DOT_LAT   = 3;
    localparam int LVM_LAT   = 1 + NORM_LAT + 2 + NORM_LAT + 2 + DOT_LAT;

    typedef struct packed {
        logic [2:0][W_W-1:0] w;
        logic [2:0]          neg;
        logic                zero;
    } nrm_side_t;

    function automatic logic [RND_W-1:0] round_fix(input logic [DOT_W-1:0] x);
        logic [DOT_W-1:0] t;
        t = x + {{(DOT_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
        return t[DOT_W-1:FRAC_BITS];
    endfunction

    function automatic logic [IN_W-1:0] sat_fix(input logic [RND_W-1:0] x);
        logic fits;
        fits = (x[RND_W-1:IN_W-1] == '0) || (x[RND_W-1:IN_W-1] == '1);
        if (fits)
            return x[IN_W-1:0];
        else if (x[RND_W-1])
            return {1'b1, {(IN_W - 1){1'b0}}};
        else
            return {1'b0, {(IN_W - 1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

@@ design/look_at_view_matrix.sv @@
// Left-handed look-at view matrix: top level, cross products and alignment delay lines.
// Depends on lvm_pkg, lvm_norm and lvm_dot.
//
//  channel   handshake            fields
//  request   start / busy         eye_*, target_*, up_* (signed Q16.16)
//  result    done (one cycle)     right_*, upaxis_*, fwd_*, trans_* (signed Q16.16)
//
// A request enters on every cycle; busy stays low.
// The delay from a request to its result is set by the two
// normalizers in series (32-step square root and 17-step divide each).
// Reset clears all valid bits; the data registers are not reset.
// The result side has no stall, so the pipeline advances every cycle.
`default_nettype none

module look_at_view_matrix
    import lvm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [IN_W-1:0] eye_x,
    input  logic [IN_W-1:0] eye_y,
    input  logic [IN_W-1:0] eye_z,
    input  logic [IN_W-1:0] target_x,
    input  logic [IN_W-1:0] target_y,
    input  logic [IN_W-1:0] target_z,
    input  logic [IN_W-1:0] up_x,
    input  logic [IN_W-1:0] up_y,
    input  logic [IN_W-1:0] up_z,
    output logic            done,
    output logic [IN_W-1:0] right_x,
    output logic [IN_W-1:0] right_y,
    output logic [IN_W-1:0] right_z,
    output logic [IN_W-1:0] upaxis_x,
    output logic [IN_W-1:0] upaxis_y,
    output logic [IN_W-1:0] upaxis_z,
    output logic [IN_W-1:0] fwd_x,
    output logic [IN_W-1:0] fwd_y,
    output logic [IN_W-1:0] fwd_z,
    output logic [IN_W-1:0] trans_right,
    output logic [IN_W-1:0] trans_up,
    output logic [IN_W-1:0] trans_fwd
);

    logic [2:0][IN_W-1:0] eye_in, tgt_in, up_in;

    logic                  s0_valid_reg;
    logic [2:0][D_W-1:0]   s0_d_reg;
    logic [2:0][NE_W-1:0]  s0_ne_reg;
    logic [2:0][IN_W-1:0]  s0_up_reg;
    logic [2:0][NORM_W-1:0] s0_vec;

    logic [2:0][NE_W-1:0] l1_ne_reg [NORM_LAT];
    logic [2:0][IN_W-1:0] l1_up_reg [NORM_LAT];

    logic                 nf_valid;
    logic [2:0][AX_W-1:0] nf_axis;

    logic                  c1_valid_reg, c2_valid_reg;
    logic [5:0][CP_W-1:0]  c1_p_reg;
    logic [2:0][NE_W-1:0]  c1_ne_reg, c2_ne_reg;
    logic [2:0][AX_W-1:0]  c1_f_reg, c2_f_reg;
    logic [2:0][NORM_W-1:0] c2_c_reg;
    logic [2:0][NORM_W-1:0] c2_c_next;

    logic [2:0][NE_W-1:0] l2_ne_reg [NORM_LAT];
    logic [2:0][AX_W-1:0] l2_f_reg  [NORM_LAT];

    logic                 nr_valid;
    logic [2:0][AX_W-1:0] nr_axis;

    logic                   u1_valid_reg, u2_valid_reg;
    logic [5:0][UP_PW-1:0]  u1_p_reg;
    logic [2:0][AX_W-1:0]   u1_r_reg, u1_f_reg, u2_r_reg, u2_f_reg;
    logic [2:0][NE_W-1:0]   u1_ne_reg, u2_ne_reg;
    logic [2:0][UP_W-1:0]   u2_u_reg;
    logic [2:0][UP_W-1:0]   u2_u_next;
    logic [RND_W-1:0]       u_rnd;
    logic signed [UP_PW:0]  u_diff;

    logic [2:0][UP_W-1:0] dot_r, dot_f;

    logic [2:0][AX_W-1:0] l3_r_reg [DOT_LAT];
    logic [2:0][UP_W-1:0] l3_u_reg [DOT_LAT];
    logic [2:0][AX_W-1:0] l3_f_reg [DOT_LAT];

    logic dr_valid, du_valid, dfw_valid;
    logic [IN_W-1:0] dr_val, du_val, dfw_val;

    assign busy   = 1'b0;
    assign eye_in = {eye_z, eye_y, eye_x};
    assign tgt_in = {target_z, target_y, target_x};
    assign up_in  = {up_z, up_y, up_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            u1_valid_reg <= 1'b0;
            u2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            c1_valid_reg <= nf_valid;
            c2_valid_reg <= c1_valid_reg;
            u1_valid_reg <= nr_valid;
            u2_valid_reg <= u1_valid_reg;
        end
    end

    // form the direction and the negated eye
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s0_d_reg[i]  <= D_W'($signed(tgt_in[i])) - D_W'($signed(eye_in[i]));
            s0_ne_reg[i] <= NE_W'(0) - NE_W'($signed(eye_in[i]));
        end
        s0_up_reg <= up_in;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s0_vec[i] = {{(NORM_W - D_W){s0_d_reg[i][D_W-1]}}, s0_d_reg[i]};
    end

    lvm_norm u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .vec       (s0_vec),
        .out_valid (nf_valid),
        .axis      (nf_axis)
    );

    always_ff @(posedge clk)
    begin
        l1_ne_reg[0] <= s0_ne_reg;
        l1_up_reg[0] <= s0_up_reg;
        for (int i = 1; i < NORM_LAT; i++)
        begin
            l1_ne_reg[i] <= l1_ne_reg[i-1];
            l1_up_reg[i] <= l1_up_reg[i-1];
        end
    end

    // up hint cross forward
    always_comb
    begin
        c2_c_next[0] = NORM_W'($signed(c1_p_reg[0])) - NORM_W'($signed(c1_p_reg[1]));
        c2_c_next[1] = NORM_W'($signed(c1_p_reg[2])) - NORM_W'($signed(c1_p_reg[3]));
        c2_c_next[2] = NORM_W'($signed(c1_p_reg[4])) - NORM_W'($signed(c1_p_reg[5]));
    end

    always_ff @(posedge clk)
    begin
        c1_p_reg[0] <= CP_W'($signed(l1_up_reg[NORM_LAT-1][1]) * $signed(nf_axis[2]));
        c1_p_reg[1] <= CP_W'($signed(l1_up_reg[NORM_LAT-1][2]) * $signed(nf_axis[1]));
        c1_p_reg[2] <= CP_W'($signed(l1_up_reg[NORM_LAT-1][2]) * $signed(nf_axis[0]));
        c1_p_reg[3] <= CP_W'($signed(l1_up_reg[NORM_LAT-1][0]) * $signed(nf_axis[2]));
        c1_p_reg[4] <= CP_W'($signed(l1_up_reg[NORM_LAT-1][0]) * $signed(nf_axis[1]));
        c1_p_reg[5] <= CP_W'($signed(l1_up_reg[NORM_LAT-1][1]) * $signed(nf_axis[0]));
        c1_ne_reg   <= l1_ne_reg[NORM_LAT-1];
        c1_f_reg    <= nf_axis;
        c2_c_reg    <= c2_c_next;
        c2_ne_reg   <= c1_ne_reg;
        c2_f_reg    <= c1_f_reg;
    end

    lvm_norm u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c2_valid_reg),
        .vec       (c2_c_reg),
        .out_valid (nr_valid),
        .axis      (nr_axis)
    );

    always_ff @(posedge clk)
    begin
        l2_ne_reg[0] <= c2_ne_reg;
        l2_f_reg[0]  <= c2_f_reg;
        for (int i = 1; i < NORM_LAT; i++)
        begin
            l2_ne_reg[i] <= l2_ne_reg[i-1];
            l2_f_reg[i]  <= l2_f_reg[i-1];
        end
    end

    // forward cross right, rounded
    always_comb
    begin
        u_diff = '0;
        u_rnd  = '0;
        for (int i = 0; i < 3; i++)
        begin
            u_diff = $signed(u1_p_reg[2*i]) - $signed(u1_p_reg[2*i+1]);
            u_rnd  = round_fix(DOT_W'(u_diff));
            u2_u_next[i] = u_rnd[UP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        u1_p_reg[0] <= UP_PW'($signed(l2_f_reg[NORM_LAT-1][1]) * $signed(nr_axis[2]));
        u1_p_reg[1] <= UP_PW'($signed(l2_f_reg[NORM_LAT-1][2]) * $signed(nr_axis[1]));
        u1_p_reg[2] <= UP_PW'($signed(l2_f_reg[NORM_LAT-1][2]) * $signed(nr_axis[0]));
        u1_p_reg[3] <= UP_PW'($signed(l2_f_reg[NORM_LAT-1][0]) * $signed(nr_axis[2]));
        u1_p_reg[4] <= UP_PW'($signed(l2_f_reg[NORM_LAT-1][0]) * $signed(nr_axis[1]));
        u1_p_reg[5] <= UP_PW'($signed(l2_f_reg[NORM_LAT-1][1]) * $signed(nr_axis[0]));
        u1_r_reg    <= nr_axis;
        u1_f_reg    <= l2_f_reg[NORM_LAT-1];
        u1_ne_reg   <= l2_ne_reg[NORM_LAT-1];
        u2_u_reg    <= u2_u_next;
        u2_r_reg    <= u1_r_reg;
        u2_f_reg    <= u1_f_reg;
        u2_ne_reg   <= u1_ne_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dot_r[i] = UP_W'($signed(u2_r_reg[i]));
            dot_f[i] = UP_W'($signed(u2_f_reg[i]));
        end
    end

    lvm_dot u_dot_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u2_valid_reg),
        .a         (dot_r),
        .ne        (u2_ne_reg),
        .out_valid (dr_valid),
        .out_val   (dr_val)
    );

    lvm_dot u_dot_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u2_valid_reg),
        .a         (u2_u_reg),
        .ne        (u2_ne_reg),
        .out_valid (du_valid),
        .out_val   (du_val)
    );

    lvm_dot u_dot_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u2_valid_reg),
        .a         (dot_f),
        .ne        (u2_ne_reg),
        .out_valid (dfw_valid),
        .out_val   (dfw_val)
    );

    always_ff @(posedge clk)
    begin
        l3_r_reg[0] <= u2_r_reg;
        l3_u_reg[0] <= u2_u_reg;
        l3_f_reg[0] <= u2_f_reg;
        for (int i = 1; i < DOT_LAT; i++)
        begin
            l3_r_reg[i] <= l3_r_reg[i-1];
            l3_u_reg[i] <= l3_u_reg[i-1];
            l3_f_reg[i] <= l3_f_reg[i-1];
        end
    end

    assign done        = dr_valid && du_valid && dfw_valid;
    assign right_x     = IN_W'($signed(l3_r_reg[DOT_LAT-1][0]));
    assign right_y     = IN_W'($signed(l3_r_reg[DOT_LAT-1][1]));
    assign right_z     = IN_W'($signed(l3_r_reg[DOT_LAT-1][2]));
    assign upaxis_x    = IN_W'($signed(l3_u_reg[DOT_LAT-1][0]));
    assign upaxis_y    = IN_W'($signed(l3_u_reg[DOT_LAT-1][1]));
    assign upaxis_z    = IN_W'($signed(l3_u_reg[DOT_LAT-1][2]));
    assign fwd_x       = IN_W'($signed(l3_f_reg[DOT_LAT-1][0]));
    assign fwd_y       = IN_W'($signed(l3_f_reg[DOT_LAT-1][1]));
    assign fwd_z       = IN_W'($signed(l3_f_reg[DOT_LAT-1][2]));
    assign trans_right = dr_val;
    assign trans_up    = du_val;
    assign trans_fwd   = dfw_val;

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LVM_LAT done)
        else $error("request did not produce a result after the pipeline latency");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LVM_LAT))
        else $error("result without a matching request");

    a_zero_fwd : assert property (@(posedge clk) disable iff (!rst_n)
        (done && fwd_x == '0 && fwd_y == '0 && fwd_z == '0) |->
            (right_x == '0 && right_y == '0 && right_z == '0 && trans_fwd == '0))
        else $error("zero forward axis with nonzero right axis");

    a_zero_right : assert property (@(posedge clk) disable iff (!rst_n)
        (done && right_x == '0 && right_y == '0 && right_z == '0) |->
            (upaxis_x == '0 && upaxis_y == '0 && upaxis_z == '0 &&
             trans_right == '0 && trans_up == '0))
        else $error("zero right axis with nonzero up axis");

endmodule

`default_nettype wire

@@ design/lvm_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with sideband carried along.
// Depends on lvm_pkg.
`default_nettype none

module lvm_isqrt
    import lvm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [SQ_W-1:0]  in_n,
    input  nrm_side_t        in_side,
    output logic             out_valid,
    output logic [LEN_W-1:0] out_len,
    output nrm_side_t        out_side
);

    logic            vld_reg  [ISQ_STEPS];
    logic [SQ_W-1:0] n_reg    [ISQ_STEPS];
    logic [SQ_W-1:0] res_reg  [ISQ_STEPS];
    nrm_side_t       side_reg [ISQ_STEPS];

    genvar s;
    for (s = 0; s < ISQ_STEPS; s++)
    begin : g_step
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - s));
        logic            src_vld;
        logic [SQ_W-1:0] src_n;
        logic [SQ_W-1:0] src_res;
        nrm_side_t       src_side;
        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] n_next;
        logic [SQ_W-1:0] res_next;

        if (s == 0)
        begin : g_first
            assign src_vld  = in_valid;
            assign src_n    = in_n;
            assign src_res  = '0;
            assign src_side = in_side;
        end
        else
        begin : g_rest
            assign src_vld  = vld_reg[s-1];
            assign src_n    = n_reg[s-1];
            assign src_res  = res_reg[s-1];
            assign src_side = side_reg[s-1];
        end

        always_comb
        begin
            trial = src_res + BITV;
            if (src_n >= trial)
            begin
                n_next   = src_n - trial;
                res_next = (src_res >> 1) + BITV;
            end
            else
            begin
                n_next   = src_n;
                res_next = src_res >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else
                vld_reg[s] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            n_reg[s]    <= n_next;
            res_reg[s]  <= res_next;
            side_reg[s] <= src_side;
        end
    end

    assign out_valid = vld_reg[ISQ_STEPS-1];
    assign out_len   = res_reg[ISQ_STEPS-1][LEN_W-1:0];
    assign out_side  = side_reg[ISQ_STEPS-1];

endmodule

`default_nettype wire

@@ design/lvm_norm.sv @@
// Vector normalizer: magnitude, scaling, sum of squares, square root and rounded divide.
// Depends on lvm_pkg and lvm_isqrt.
`default_nettype none

module lvm_norm
    import lvm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [2:0][NORM_W-1:0] vec,
    output logic                   out_valid,
    output logic [2:0][AX_W-1:0]   axis
);

    logic                  a_valid_reg, b_valid_reg, c_valid_reg;
    logic                  d_valid_reg, e_valid_reg, f_valid_reg;
    logic [2:0][MAG_W-1:0] a_mag_reg, b_mag_reg, c_mag_reg;
    logic [2:0]            a_neg_reg, b_neg_reg, c_neg_reg, d_neg_reg, e_neg_reg;
    logic [MAG_W-1:0]      b_max_reg;
    logic [BL_W-1:0]       c_bl_reg;
    logic                  c_zero_reg, d_zero_reg, e_zero_reg;
    logic [2:0][W_W-1:0]   d_w_reg, e_w_reg;
    logic [2:0][2*W_W-1:0] e_sq_reg;
    logic [SQ_W-1:0]       f_sum_reg;
    nrm_side_t             f_side_reg;

    logic [2:0][MAG_W-1:0] a_mag_next;
    logic [MAG_W-1:0]      b_max_next;
    logic [BL_W-1:0]       c_bl_next;
    logic [2:0][W_W-1:0]   d_w_next;
    logic [MAG_W-1:0]      d_shift;

    logic             sq_valid;
    logic [LEN_W-1:0] sq_len;
    nrm_side_t        sq_side;

    logic                  p_valid_reg;
    logic [2:0][NUM_W-1:0] p_num_reg;
    logic [LEN_W-1:0]      p_len_reg;
    logic [2:0]            p_neg_reg;
    logic                  p_zero_reg;

    logic                  dv_vld_reg  [DIV_STEPS];
    logic [2:0][NUM_W-1:0] dv_rem_reg  [DIV_STEPS];
    logic [2:0][Q_W-1:0]   dv_q_reg    [DIV_STEPS];
    logic [LEN_W-1:0]      dv_len_reg  [DIV_STEPS];
    logic [2:0]            dv_neg_reg  [DIV_STEPS];
    logic                  dv_zero_reg [DIV_STEPS];

    logic                o_valid_reg;
    logic [2:0][AX_W-1:0] o_axis_reg;
    logic [2:0][AX_W-1:0] o_axis_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            a_mag_next[i] = vec[i][NORM_W-1] ? (~vec[i] + 1'b1) : vec[i];

        b_max_next = (a_mag_reg[0] > a_mag_reg[1]) ? a_mag_reg[0] : a_mag_reg[1];
        if (a_mag_reg[2] > b_max_next)
            b_max_next = a_mag_reg[2];

        c_bl_next = '0;
        for (int i = 0; i < MAG_W; i++)
            if (b_max_reg[i])
                c_bl_next = BL_W'(i + 1);

        for (int i = 0; i < 3; i++)
        begin
            if (c_bl_reg > BL_W'(W_W))
                d_shift = c_mag_reg[i] >> (c_bl_reg - BL_W'(W_W));
            else
                d_shift = c_mag_reg[i] << (BL_W'(W_W) - c_bl_reg);
            d_w_next[i] = d_shift[W_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            p_valid_reg <= sq_valid;
            o_valid_reg <= dv_vld_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg <= a_mag_next;
        for (int i = 0; i < 3; i++)
            a_neg_reg[i] <= vec[i][NORM_W-1];

        b_mag_reg <= a_mag_reg;
        b_neg_reg <= a_neg_reg;
        b_max_reg <= b_max_next;

        c_mag_reg  <= b_mag_reg;
        c_neg_reg  <= b_neg_reg;
        c_bl_reg   <= c_bl_next;
        c_zero_reg <= (b_max_reg == '0);

        d_w_reg    <= d_w_next;
        d_neg_reg  <= c_neg_reg;
        d_zero_reg <= c_zero_reg;

        for (int i = 0; i < 3; i++)
            e_sq_reg[i] <= {{W_W{1'b0}}, d_w_reg[i]} * {{W_W{1'b0}}, d_w_reg[i]};
        e_w_reg    <= d_w_reg;
        e_neg_reg  <= d_neg_reg;
        e_zero_reg <= d_zero_reg;

        f_sum_reg       <= SQ_W'(e_sq_reg[0]) + SQ_W'(e_sq_reg[1]) + SQ_W'(e_sq_reg[2]);
        f_side_reg.w    <= e_w_reg;
        f_side_reg.neg  <= e_neg_reg;
        f_side_reg.zero <= e_zero_reg;

        for (int i = 0; i < 3; i++)
            p_num_reg[i] <= NUM_W'({sq_side.w[i], {FRAC_BITS{1'b0}}}) + NUM_W'(sq_len >> 1);
        p_len_reg  <= sq_len;
        p_neg_reg  <= sq_side.neg;
        p_zero_reg <= sq_side.zero;

        o_axis_reg <= o_axis_next;
    end

    lvm_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid_reg),
        .in_n      (f_sum_reg),
        .in_side   (f_side_reg),
        .out_valid (sq_valid),
        .out_len   (sq_len),
        .out_side  (sq_side)
    );

    genvar k;
    for (k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int SH = Q_W - 1 - k;
        logic                  src_vld;
        logic [2:0][NUM_W-1:0] src_rem;
        logic [2:0][Q_W-1:0]   src_q;
        logic [LEN_W-1:0]      src_len;
        logic [2:0]            src_neg;
        logic                  src_zero;
        logic [NUM_W-1:0]      dsh;
        logic [2:0][NUM_W-1:0] rem_next;
        logic [2:0][Q_W-1:0]   q_next;

        if (k == 0)
        begin : g_first
            assign src_vld  = p_valid_reg;
            assign src_rem  = p_num_reg;
            assign src_q    = '0;
            assign src_len  = p_len_reg;
            assign src_neg  = p_neg_reg;
            assign src_zero = p_zero_reg;
        end
        else
        begin : g_rest
            assign src_vld  = dv_vld_reg[k-1];
            assign src_rem  = dv_rem_reg[k-1];
            assign src_q    = dv_q_reg[k-1];
            assign src_len  = dv_len_reg[k-1];
            assign src_neg  = dv_neg_reg[k-1];
            assign src_zero = dv_zero_reg[k-1];
        end

        always_comb
        begin
            dsh = NUM_W'(src_len) << SH;
            for (int i = 0; i < 3; i++)
            begin
                if (src_rem[i] >= dsh)
                begin
                    rem_next[i] = src_rem[i] - dsh;
                    q_next[i]   = src_q[i] | (Q_W'(1) << SH);
                end
                else
                begin
                    rem_next[i] = src_rem[i];
                    q_next[i]   = src_q[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[k] <= 1'b0;
            else
                dv_vld_reg[k] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[k]  <= rem_next;
            dv_q_reg[k]    <= q_next;
            dv_len_reg[k]  <= src_len;
            dv_neg_reg[k]  <= src_neg;
            dv_zero_reg[k] <= src_zero;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_zero_reg[DIV_STEPS-1])
                o_axis_next[i] = '0;
            else if (dv_neg_reg[DIV_STEPS-1][i])
                o_axis_next[i] = AX_W'(0) - AX_W'(dv_q_reg[DIV_STEPS-1][i]);
            else
                o_axis_next[i] = AX_W'(dv_q_reg[DIV_STEPS-1][i]);
        end
    end

    assign out_valid = o_valid_reg;
    assign axis      = o_axis_reg;

endmodule

`default_nettype wire

@@ design/lvm_dot.sv @@
// Three-stage dot product with the negated eye, rounded and saturated to 32 bits.
// Depends on lvm_pkg.
`default_nettype none

module lvm_dot
    import lvm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [2:0][UP_W-1:0] a,
    input  logic [2:0][NE_W-1:0] ne,
    output logic                 out_valid,
    output logic [IN_W-1:0]      out_val
);

    logic                 p_valid_reg, s_valid_reg, o_valid_reg;
    logic [2:0][DP_W-1:0] p_prod_reg;
    logic [DOT_W-1:0]     s_sum_reg;
    logic [IN_W-1:0]      o_val_reg;
    logic signed [DOT_W-1:0] sum_next;

    always_comb
    begin
        sum_next = $signed(p_prod_reg[0]) + $signed(p_prod_reg[1]) + $signed(p_prod_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            s_valid_reg <= p_valid_reg;
            o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            p_prod_reg[i] <= DP_W'($signed(a[i]) * $signed(ne[i]));
        s_sum_reg <= sum_next;
        o_val_reg <= sat_fix(round_fix(s_sum_reg));
    end

    assign out_valid = o_valid_reg;
    assign out_val   = o_val_reg;

endmodule

`default_nettype wire
